// ----- src/irle_pkg.sv -----
// Shared types and constants of the run-length pixel decoder.
// No dependencies; every other file of the block uses this package.
package irle_pkg;

   // Width of the pixel counters and of the configuration data
   localparam int COUNT_BITS = 24;

   // Configuration register indexes
   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COMPRESSED_MODE = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PIXEL_COUNT     = 1'b1;

   // Control byte thresholds
   localparam logic [7:0] ZERO_RUN_BASE  = 8'd128;
   localparam logic [7:0] VALUE_RUN_BASE = 8'd192;

   // Run queue between front and back
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // One decoded run
   typedef struct packed {
      logic [7:0] pixel_value;
      logic [7:0] run_length;
      logic       image_done;
      logic       overrun;
   } run_type;

   // Front to queue: one run to be written
   typedef struct packed {
      logic    valid;
      run_type run;
   } push_type;

endpackage

// ----- src/irle_front.sv -----
// Front end: configuration registers, byte classification, pixel counting
// and run clipping. Depends on irle_pkg; feeds irle_queue.
module irle_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [irle_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [irle_pkg::COUNT_BITS-1:0]     csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_byte_in,
   input  logic                                req_start_image,
   input  logic                                queue_full,
   output irle_pkg::push_type                  push
);

   typedef enum logic [1:0] {
      PH_CTRL = 2'd0,
      PH_LIT  = 2'd1,
      PH_VAL  = 2'd2
   } phase_type;

   phase_type                       phase_ff, phase_in, phase_cur;
   logic [7:0]                      literals_left_ff, literals_left_in, lit_cur, lit_dec;
   logic [5:0]                      pending_run_ff, pending_run_in, pend_cur;
   logic [irle_pkg::COUNT_BITS-1:0] pixels_left_ff, pixels_left_in, pl_cur;
   logic                            compressed_mode_ff;
   logic [irle_pkg::COUNT_BITS-1:0] pixel_count_ff;
   logic                            accept;
   logic                            emit;
   logic                            extra_clip;
   logic                            clip;
   logic [7:0]                      run_value;
   logic [7:0]                      run_len;
   logic [7:0]                      len_out;
   logic [7:0]                      byte_diff;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Decode one byte against the current state
   always_comb begin
      pl_cur     = req_start_image ? pixel_count_ff : pixels_left_ff;
      phase_cur  = req_start_image ? PH_CTRL : phase_ff;
      lit_cur    = req_start_image ? 8'd0 : literals_left_ff;
      pend_cur   = req_start_image ? 6'd0 : pending_run_ff;
      lit_dec    = lit_cur - 8'd1;
      byte_diff  = 8'd0;
      emit       = 1'b0;
      extra_clip = 1'b0;
      run_value  = 8'd0;
      run_len    = 8'd0;
      phase_in         = phase_cur;
      literals_left_in = lit_cur;
      pending_run_in   = pend_cur;

      if (pl_cur != '0) begin
         unique case (phase_cur)
            PH_LIT: begin
               // one literal pixel; end of image cuts the block short
               emit       = 1'b1;
               run_value  = req_byte_in;
               run_len    = 8'd1;
               extra_clip = (pl_cur == irle_pkg::COUNT_BITS'(1)) && (lit_dec != 8'd0);
               if ((lit_dec == 8'd0) || (pl_cur == irle_pkg::COUNT_BITS'(1))) begin
                  phase_in         = PH_CTRL;
                  literals_left_in = 8'd0;
               end else begin
                  literals_left_in = lit_dec;
               end
            end
            PH_VAL: begin
               // value byte of a pending run
               emit           = 1'b1;
               run_value      = req_byte_in;
               run_len        = {2'b00, pend_cur};
               phase_in       = PH_CTRL;
               pending_run_in = 6'd0;
            end
            default: begin
               // control byte
               phase_in = PH_CTRL;
               if (compressed_mode_ff) begin
                  byte_diff = req_byte_in - irle_pkg::ZERO_RUN_BASE;
                  if (req_byte_in > irle_pkg::ZERO_RUN_BASE) begin
                     emit    = 1'b1;
                     run_len = byte_diff;
                  end else if (req_byte_in != 8'd0) begin
                     literals_left_in = req_byte_in;
                     phase_in         = PH_LIT;
                  end
               end else begin
                  byte_diff = req_byte_in - irle_pkg::VALUE_RUN_BASE;
                  if (req_byte_in > irle_pkg::VALUE_RUN_BASE) begin
                     pending_run_in = byte_diff[5:0];
                     phase_in       = PH_VAL;
                  end else begin
                     emit      = 1'b1;
                     run_value = req_byte_in;
                     run_len   = 8'd1;
                  end
               end
            end
         endcase
      end

      // clip the run to the pixels still owed
      clip    = irle_pkg::COUNT_BITS'(run_len) > pl_cur;
      len_out = clip ? pl_cur[7:0] : run_len;
      pixels_left_in = emit ? (pl_cur - irle_pkg::COUNT_BITS'(len_out)) : pl_cur;

      push.valid           = accept && emit;
      push.run.pixel_value = run_value;
      push.run.run_length  = len_out;
      push.run.image_done  = (pixels_left_in == '0);
      push.run.overrun     = extra_clip || clip;
   end

   // State and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_CTRL;
         literals_left_ff   <= 8'd0;
         pending_run_ff     <= 6'd0;
         pixels_left_ff     <= '0;
         compressed_mode_ff <= 1'b0;
         pixel_count_ff     <= '0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               irle_pkg::CSR_COMPRESSED_MODE: compressed_mode_ff <= csr_wdata[0];
               irle_pkg::CSR_PIXEL_COUNT:     pixel_count_ff     <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            phase_ff         <= phase_in;
            literals_left_ff <= literals_left_in;
            pending_run_ff   <= pending_run_in;
            pixels_left_ff   <= pixels_left_in;
         end
      end
   end

   // A run never leaves with zero length
   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> push.run.run_length != 8'd0)
      else $error("front emitted an empty run");

   // A run flagged as last leaves no pixels owed
   a_done_empties: assert property (@(posedge clock) disable iff (reset)
      push.valid && push.run.image_done |=> pixels_left_ff == '0)
      else $error("image_done set with pixels still owed");

   // Waiting for a value byte implies a nonzero pending run
   a_pending_set: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_VAL |-> pending_run_ff != 6'd0)
      else $error("value phase without a pending run");

endmodule

// ----- src/irle_queue.sv -----
// Short run queue that decouples the front end from the output stage.
// Depends on irle_pkg.
module irle_queue (
   input  logic               clock,
   input  logic               reset,
   input  irle_pkg::push_type push,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output irle_pkg::run_type  head_run
);

   irle_pkg::run_type                   entry_ff [irle_pkg::QUEUE_DEPTH];
   logic [irle_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [irle_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                                do_pop;

   assign full       = (count_ff == irle_pkg::QUEUE_CNT_BITS'(irle_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_run   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Occupancy
   always_comb begin
      count_in = count_ff;
      if (push.valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.run;
      end
   end

   // Pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // Front end never writes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("run queue overflow");

   // Occupancy tracks the pointer distance
   a_count_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff != irle_pkg::QUEUE_CNT_BITS'(irle_pkg::QUEUE_DEPTH)) |->
      (irle_pkg::QUEUE_PTR_BITS'(wr_ptr_ff - rd_ptr_ff) ==
       count_ff[irle_pkg::QUEUE_PTR_BITS-1:0]))
      else $error("run queue count and pointers disagree");

endmodule

// ----- src/irle_back.sv -----
// Output stage: holds one run on the response channel until it is taken.
// Depends on irle_pkg; reads from irle_queue.
module irle_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  irle_pkg::run_type head_run,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output irle_pkg::run_type rsp_run
);

   logic              rsp_valid_ff;
   irle_pkg::run_type rsp_run_ff;

   // Refill when the register is empty or being drained
   assign pop       = head_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_run   = rsp_run_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_run_ff <= head_run;
      end
   end

   // A run taken from the queue is presented next cycle
   a_pop_shows: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("popped run not presented");

endmodule

// ----- src/image_rle_pixel_decoder_unit.sv -----
// Run-length pixel decoder for 8-bit paletted images: one raw byte per
// request, at most one (pixel, run length) response per byte. Set the mode and
// the pixel count through the CSR port while idle, then mark the first byte of
// each image with req_start_image. Every byte is decoded in the cycle it is
// accepted, so a new request is taken each clock while the queue has room; the
// front end's combinational compare/subtract on the pixel counter sets that
// rate. Runs pass through a four-entry queue and then an output register on the
// way to the response, and requests stall only when the queue fills under
// response back-pressure.
module image_rle_pixel_decoder_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [irle_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [irle_pkg::COUNT_BITS-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_byte_in,
   input  logic                              req_start_image,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_pixel_value,
   output logic [7:0]                        rsp_run_length,
   output logic                              rsp_image_done,
   output logic                              rsp_overrun
);

   irle_pkg::push_type push;
   irle_pkg::run_type  head_run;
   irle_pkg::run_type  rsp_run;
   logic               queue_full;
   logic               head_valid;
   logic               pop;

   irle_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_byte_in     (req_byte_in),
      .req_start_image (req_start_image),
      .queue_full      (queue_full),
      .push            (push)
   );

   irle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_run   (head_run)
   );

   irle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_run   (head_run),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_run    (rsp_run)
   );

   assign rsp_pixel_value = rsp_run.pixel_value;
   assign rsp_run_length  = rsp_run.run_length;
   assign rsp_image_done  = rsp_run.image_done;
   assign rsp_overrun     = rsp_run.overrun;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Testbench of image_rle_pixel_decoder_unit: directed and random byte streams.
// It predicts every run from its own decoder model and checks each response.
// Depends on irle_pkg and the RTL of the unit only.
module tb;

   localparam int RANDOM_ITEMS = 1550;
   localparam int DRAIN_CYCLES = 12;

   typedef enum logic [1:0] {
      PHASE_CONTROL = 2'd0,
      PHASE_LITERAL = 2'd1,
      PHASE_VALUE   = 2'd2
   } decode_phase_type;

   typedef struct packed {
      logic [7:0] byte_val;
      logic       start;
   } pixel_req_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              csr_write_en = 1'b0;
   logic [irle_pkg::CSR_IDX_BITS-1:0] csr_index = '0;
   logic [irle_pkg::COUNT_BITS-1:0]   csr_wdata = '0;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [7:0]                        req_byte_in = 8'd0;
   logic                              req_start_image = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [7:0]                        rsp_pixel_value;
   logic [7:0]                        rsp_run_length;
   logic                              rsp_image_done;
   logic                              rsp_overrun;

   image_rle_pixel_decoder_unit uut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_byte_in     (req_byte_in),
      .req_start_image (req_start_image),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_run_length  (rsp_run_length),
      .rsp_image_done  (rsp_image_done),
      .rsp_overrun     (rsp_overrun)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Decoder model: configuration copy and state
   logic                            cfg_compressed = 1'b0;
   logic [irle_pkg::COUNT_BITS-1:0] cfg_pixel_count = '0;
   decode_phase_type                phase_q = PHASE_CONTROL;
   logic [7:0]                      literals_q = 8'd0;
   logic [5:0]                      run_pending_q = 6'd0;
   logic [irle_pkg::COUNT_BITS-1:0] pixels_left_q = '0;

   pixel_req_type     pending_reqs[$];
   irle_pkg::run_type expected_runs[$];
   int                mismatches = 0;
   int                stim_items = 0;

   bit                req_fire = 1'b0;
   bit                rsp_fire = 1'b0;
   int                req_gap = 0;
   int                req_burst = 0;
   int                rsp_stall = 0;
   int                rsp_burst = 0;
   pixel_req_type     next_req;
   irle_pkg::run_type want_run;
   irle_pkg::run_type new_run;
   bit                new_valid;

   // Emit one run, shortened to the pixels still owed by the image
   function automatic irle_pkg::run_type clip_run(input logic [7:0] value,
                                                  input logic [7:0] len,
                                                  input logic extra_clip);
      irle_pkg::run_type               r;
      logic [irle_pkg::COUNT_BITS-1:0] n;
      n = irle_pkg::COUNT_BITS'(len);
      r.overrun = extra_clip;
      if (n > pixels_left_q) begin
         n = pixels_left_q;
         r.overrun = 1'b1;
      end
      pixels_left_q = pixels_left_q - n;
      r.pixel_value = value;
      r.run_length  = n[7:0];
      r.image_done  = (pixels_left_q == '0);
      return r;
   endfunction

   // Decode one accepted byte; got is set when it yields a run
   function automatic void decode_byte(input logic [7:0] b, input logic start,
                                       output bit got, output irle_pkg::run_type r);
      logic clip;
      logic [5:0] len;
      got = 1'b0;
      r   = '0;
      if (start) begin
         phase_q       = PHASE_CONTROL;
         literals_q    = 8'd0;
         run_pending_q = 6'd0;
         pixels_left_q = cfg_pixel_count;
      end
      if (pixels_left_q == '0) return;
      case (phase_q)
         PHASE_LITERAL: begin
            literals_q = literals_q - 8'd1;
            clip = (pixels_left_q == irle_pkg::COUNT_BITS'(1)) && (literals_q != 8'd0);
            if (literals_q == 8'd0 || pixels_left_q == irle_pkg::COUNT_BITS'(1)) begin
               phase_q    = PHASE_CONTROL;
               literals_q = 8'd0;
            end
            r   = clip_run(b, 8'd1, clip);
            got = 1'b1;
         end
         PHASE_VALUE: begin
            len           = run_pending_q;
            phase_q       = PHASE_CONTROL;
            run_pending_q = 6'd0;
            r   = clip_run(b, {2'b00, len}, 1'b0);
            got = 1'b1;
         end
         default: begin
            phase_q = PHASE_CONTROL;
            if (cfg_compressed) begin
               if (b > irle_pkg::ZERO_RUN_BASE) begin
                  r   = clip_run(8'd0, b - irle_pkg::ZERO_RUN_BASE, 1'b0);
                  got = 1'b1;
               end else if (b != 8'd0) begin
                  literals_q = b;
                  phase_q    = PHASE_LITERAL;
               end
            end else if (b > irle_pkg::VALUE_RUN_BASE) begin
               run_pending_q = 6'(b - irle_pkg::VALUE_RUN_BASE);
               phase_q       = PHASE_VALUE;
            end else begin
               r   = clip_run(b, 8'd1, 1'b0);
               got = 1'b1;
            end
         end
      endcase
   endfunction

   // Wait for one handshake: a random gap, with occasional stretches of none
   function automatic int draw_wait(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 10);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic queue_request(input logic [7:0] b, input logic start);
      pixel_req_type item;
      item.byte_val = b;
      item.start    = start;
      pending_reqs.push_back(item);
      if (cfg_pixel_count != '0) stim_items++;
   endtask

   // Registers change only while the unit is idle
   task automatic write_csr(input logic [irle_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [irle_pkg::COUNT_BITS-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      if (idx == irle_pkg::CSR_COMPRESSED_MODE) cfg_compressed = data[0];
      else cfg_pixel_count = data;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Sampled at the rising edge, where the driver's outputs are stable
   task automatic wait_idle();
      @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_runs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Well-formed image stream with random content and some noise
   task automatic queue_image(input int pixels, input int max_bytes, input bit with_start);
      int   left;
      int   used;
      int   n;
      int   pick;
      logic first;
      left  = pixels;
      used  = 0;
      first = with_start;
      while (left > 0 && used < max_bytes) begin
         pick = $urandom_range(0, 99);
         if (cfg_compressed) begin
            if (pick < 40) begin
               n = (pick < 30) ? $urandom_range(1, 16) : $urandom_range(1, 127);
               queue_request(8'(128 + n), first);
               left -= n;
            end else if (pick < 85) begin
               n = (pick < 80) ? $urandom_range(1, 12) : $urandom_range(1, 128);
               queue_request(8'(n), first);
               repeat (n) queue_request(8'($urandom_range(0, 255)), 1'b0);
               used += n;
               left -= n;
            end else if (pick < 92) begin
               queue_request(8'd0, first);
            end else begin
               queue_request(8'($urandom_range(0, 255)), first | ($urandom_range(0, 3) == 0));
            end
         end else begin
            if (pick < 50) begin
               queue_request(8'($urandom_range(0, 192)), first);
               left -= 1;
            end else if (pick < 90) begin
               n = $urandom_range(1, 63);
               queue_request(8'(192 + n), first);
               queue_request(8'($urandom_range(0, 255)), 1'b0);
               used++;
               left -= n;
            end else begin
               queue_request(8'($urandom_range(0, 255)), first | ($urandom_range(0, 3) == 0));
            end
         end
         used++;
         first = 1'b0;
      end
   endtask

   // Request driver: holds each request until accepted, then idles a drawn gap
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (pending_reqs.size() != 0) begin
            next_req = pending_reqs.pop_front();
            req_byte_in     <= next_req.byte_val;
            req_start_image <= next_req.start;
            req_valid       <= 1'b1;
            req_gap = draw_wait(req_burst);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response back-pressure: drop ready for a drawn stall after each response
   always @(negedge clock) begin
      if (rsp_fire) rsp_stall = draw_wait(rsp_burst);
      if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: check responses, then predict from accepted requests
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && req_ready;
      rsp_fire <= !reset && rsp_valid && rsp_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_runs.size() == 0) begin
            report_mismatch($sformatf("unexpected run pixel %0d length %0d",
                                      rsp_pixel_value, rsp_run_length));
         end else begin
            want_run = expected_runs.pop_front();
            if (rsp_pixel_value !== want_run.pixel_value)
               report_mismatch($sformatf("pixel_value got %0d expected %0d",
                                         rsp_pixel_value, want_run.pixel_value));
            if (rsp_run_length !== want_run.run_length)
               report_mismatch($sformatf("run_length got %0d expected %0d",
                                         rsp_run_length, want_run.run_length));
            if (rsp_image_done !== want_run.image_done)
               report_mismatch($sformatf("image_done got %0b expected %0b",
                                         rsp_image_done, want_run.image_done));
            if (rsp_overrun !== want_run.overrun)
               report_mismatch($sformatf("overrun got %0b expected %0b",
                                         rsp_overrun, want_run.overrun));
         end
      end
      if (!reset && req_valid && req_ready) begin
         decode_byte(req_byte_in, req_start_image, new_valid, new_run);
         if (new_valid) expected_runs.push_back(new_run);
      end
   end

   // Stimulus
   initial begin
      int                              pick;
      int                              images;
      logic [irle_pkg::COUNT_BITS-1:0] count;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // No image active, then a start with a zero pixel count: all ignored
      queue_request(8'h05, 1'b0);
      queue_request(8'hC8, 1'b0);
      queue_request(8'h10, 1'b1);
      wait_idle();

      // Value-run mode: single pixels, shortest and longest runs, clipping, tail
      write_csr(irle_pkg::CSR_PIXEL_COUNT, irle_pkg::COUNT_BITS'(10));
      write_csr(irle_pkg::CSR_COMPRESSED_MODE, irle_pkg::COUNT_BITS'(0));
      queue_request(8'd5, 1'b1);
      queue_request(8'd0, 1'b0);
      queue_request(8'd192, 1'b0);
      queue_request(8'd193, 1'b0);
      queue_request(8'd77, 1'b0);
      queue_request(8'd255, 1'b0);
      queue_request(8'hAA, 1'b0);
      queue_request(8'd3, 1'b0);
      queue_request(8'd200, 1'b0);
      wait_idle();

      // Mode change while a run value is pending, then a clipped literal block
      queue_request(8'd200, 1'b1);
      wait_idle();
      write_csr(irle_pkg::CSR_COMPRESSED_MODE, irle_pkg::COUNT_BITS'(1));
      queue_request(8'd7, 1'b0);
      queue_request(8'd0, 1'b0);
      queue_request(8'd3, 1'b0);
      queue_request(8'd1, 1'b0);
      queue_request(8'd2, 1'b0);
      queue_request(8'd9, 1'b0);
      wait_idle();

      // Compressed mode: longest and shortest zero runs, literals, restart
      write_csr(irle_pkg::CSR_PIXEL_COUNT, irle_pkg::COUNT_BITS'(300));
      queue_request(8'd255, 1'b1);
      queue_request(8'd129, 1'b0);
      queue_request(8'd2, 1'b0);
      queue_request(8'hFF, 1'b0);
      queue_request(8'h00, 1'b0);
      queue_request(8'd130, 1'b1);
      wait_idle();

      // Random phases, each with its own mode and pixel count
      stim_items = 0;
      while (stim_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0:       count = '0;
            1:       count = '1;
            2:       count = irle_pkg::COUNT_BITS'($urandom());
            3, 4:    count = irle_pkg::COUNT_BITS'($urandom_range(1, 4));
            default: count = irle_pkg::COUNT_BITS'($urandom_range(5, 200));
         endcase
         if ($urandom_range(0, 3) != 0)
            write_csr(irle_pkg::CSR_COMPRESSED_MODE,
                      irle_pkg::COUNT_BITS'($urandom_range(0, 1)));
         write_csr(irle_pkg::CSR_PIXEL_COUNT, count);
         // sometimes carry on the image left over from the last phase
         if ($urandom_range(0, 3) == 0) queue_image(1000, 6, 1'b0);
         images = $urandom_range(1, 4);
         repeat (images) begin
            queue_image((count > irle_pkg::COUNT_BITS'(100000)) ? 100000 : int'(count),
                        80, 1'b1);
            repeat ($urandom_range(0, 3)) queue_request(8'($urandom_range(0, 255)), 1'b0);
         end
         wait_idle();
      end

      wait_idle();
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
